/* rtl/depth_preferred_hash_table_macros.svh */
// Assertion macros for the file that checks its own logic.
// Each check samples on the rising edge of clk and is off while rst_n is low.
`ifndef DEPTH_PREFERRED_HASH_TABLE_MACROS_SVH
`define DEPTH_PREFERRED_HASH_TABLE_MACROS_SVH

`ifndef SYNTHESIS

// The consequent must hold in the same cycle as the antecedent.
`define DPHT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define DPHT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: next-cycle check failed");

`else

`define DPHT_ASSERT_NOW(label, ante, cons)
`define DPHT_ASSERT_NEXT(label, ante, cons)

`endif

`endif

/* rtl/dpht_pkg.sv */
package dpht_pkg;

    // Action codes of an input item.
    localparam logic [1:0] ACT_PROBE = 2'd0;
    localparam logic [1:0] ACT_STORE = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    // Bound code that reads back as exact.
    localparam logic [1:0] BOUND_EXACT = 2'd0;
    localparam logic [1:0] BOUND_ALIAS = 2'd3;

    // Packed record layout.
    localparam int KEY_W     = 64;
    localparam int REC_W     = 58;
    localparam int ENTRY_W   = KEY_W + REC_W;
    localparam int MOVE_LSB  = 0;
    localparam int SCORE_LSB = 32;
    localparam int DEPTH_LSB = 48;
    localparam int BOUND_LSB = 56;

    // Store-side limits.
    localparam logic [7:0]  DEPTH_MAX = 8'd254;
    localparam logic [15:0] SCORE_POS = 16'h7FFF;
    localparam logic [15:0] SCORE_NEG = 16'h8000;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load_item;  // capture the item and start the entry read
        logic commit;     // write back if needed and load the result
        logic clr_step;   // zero one entry of the clearing sweep
    } dpht_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic item_clear; // held item is a clear action
        logic out_free;   // result register can take a new result
        logic clr_last;   // sweep is at the last entry
    } dpht_stat_t;

endpackage

/* rtl/depth_preferred_hash_table.sv */
// Direct-mapped, depth-preferred hash table of 2**INDEX_BITS entries, each
// holding a 64-bit key and a packed record of move, score, depth and bound.
// The input channel (in_valid, in_stall) takes one item per handshake: a
// probe, a store or a clear of the whole table. The output channel
// (out_valid, out_stall) returns exactly one result item per input item;
// only a probe hit carries nonzero fields.
// An item is taken in the idle state and its entry is read from the table memory
// into a register as it is taken. Once the output register is free, the
// result is formed and the entry is written back when a store is not skipped.
// The result is loaded into the output register at that point; a probe or
// store occupies the block until it commits, limited by the registered read
// and the single write port of the table memory.
// A clear returns its result at once and then sweeps the memory, one entry
// per cycle, over all 2**INDEX_BITS entries, during which in_stall stays high.
// After reset the block runs the same sweep over all 2**INDEX_BITS entries
// before it accepts its first item.
// When the receiver holds out_stall high, the finished result waits in the
// output register and the next item waits in its evaluation cycle until the
// register is free; nothing is dropped.
`include "depth_preferred_hash_table_macros.svh"

module depth_preferred_hash_table #(
    parameter int INDEX_BITS = 12
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [1:0]          action,
    input  logic [63:0]         key,
    input  logic signed [8:0]   depth,
    input  logic signed [17:0]  score,
    input  logic [1:0]          bound,
    input  logic [31:0]         move_word,
    output logic                out_valid,
    input  logic                out_stall,
    output logic                hit,
    output logic [31:0]         found_move,
    output logic signed [15:0]  found_score,
    output logic [7:0]          found_depth,
    output logic [1:0]          found_bound
);
    import dpht_pkg::*;

    // Commands and status between the controller and the datapath.
    dpht_cmd_t  cmd;
    dpht_stat_t stat;

    // The controller sequences idle, evaluation and the clearing sweep.
    dpht_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath owns the table memory, the item and the result register.
    dpht_data #(
        .INDEX_BITS (INDEX_BITS)
    ) u_data (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .action      (action),
        .key         (key),
        .depth       (depth),
        .score       (score),
        .bound       (bound),
        .move_word   (move_word),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .hit         (hit),
        .found_move  (found_move),
        .found_score (found_score),
        .found_depth (found_depth),
        .found_bound (found_bound)
    );

    // A miss or a non-probe result carries all-zero fields.
    `DPHT_ASSERT_NOW(a_miss_zero, out_valid && !hit,
        (found_move == 32'd0) && (found_score == 16'sd0) &&
        (found_depth == 8'd0) && (found_bound == 2'd0))

    // The aliased bound code never reaches the output.
    `DPHT_ASSERT_NOW(a_bound_alias, out_valid && hit, found_bound != BOUND_ALIAS)

    // A hit never reports the largest depth code, which no store can produce.
    `DPHT_ASSERT_NOW(a_depth_range, out_valid && hit, found_depth != 8'd255)

    // One item at a time: the input is stalled in the cycle after an accept.
    `DPHT_ASSERT_NEXT(a_one_item, in_valid && !in_stall, in_stall)

endmodule

/* rtl/dpht_ctrl.sv */
module dpht_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  dpht_pkg::dpht_stat_t stat,
    output dpht_pkg::dpht_cmd_t  cmd
);
    import dpht_pkg::*;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_EVAL
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   stall_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clr_step = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_EVAL;
                end
            end
            ST_EVAL:
            begin
                if (stat.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = stat.item_clear ? ST_CLEAR : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            stall_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            stall_reg <= (state_next != ST_IDLE);
        end
    end

    assign in_stall = stall_reg;

endmodule

/* rtl/dpht_data.sv */
module dpht_data #(
    parameter int INDEX_BITS = 12
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  dpht_pkg::dpht_cmd_t  cmd,
    output dpht_pkg::dpht_stat_t stat,
    input  logic [1:0]           action,
    input  logic [63:0]          key,
    input  logic signed [8:0]    depth,
    input  logic signed [17:0]   score,
    input  logic [1:0]           bound,
    input  logic [31:0]          move_word,
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic                 hit,
    output logic [31:0]          found_move,
    output logic signed [15:0]   found_score,
    output logic [7:0]           found_depth,
    output logic [1:0]           found_bound
);
    import dpht_pkg::*;

    localparam int Entries = 1 << INDEX_BITS;

    logic [ENTRY_W-1:0]    mem [Entries];
    logic [ENTRY_W-1:0]    rd_data_reg;

    logic [1:0]            act_reg;
    logic [KEY_W-1:0]      key_reg;
    logic signed [8:0]     depth_reg;
    logic signed [17:0]    score_reg;
    logic [1:0]            bound_reg;
    logic [31:0]           move_reg;

    logic [INDEX_BITS-1:0] clr_addr_reg;
    logic [INDEX_BITS-1:0] clr_addr_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;

    logic                  hit_reg;
    logic [31:0]           move_out_reg;
    logic [15:0]           score_out_reg;
    logic [7:0]            depth_out_reg;
    logic [1:0]            bound_out_reg;

    logic [INDEX_BITS-1:0] idx;
    logic [KEY_W-1:0]      entry_key;
    logic [REC_W-1:0]      rec;
    logic [7:0]            depth_field;
    logic [1:0]            bound_field;
    logic                  key_match;
    logic                  hit_next;
    logic                  skip;
    logic                  wr_en;
    logic [15:0]           score_sat;
    logic [7:0]            depth_clamp;
    logic [7:0]            depth_biased;
    logic [REC_W-1:0]      new_rec;

    assign idx         = key_reg[INDEX_BITS-1:0];
    assign entry_key   = rd_data_reg[ENTRY_W-1:REC_W];
    assign rec         = rd_data_reg[REC_W-1:0];
    assign depth_field = rec[DEPTH_LSB +: 8];
    assign bound_field = rec[BOUND_LSB +: 2];
    assign key_match   = (entry_key == key_reg);

    // A zero depth field means an empty entry (stored depth of minus one).
    assign hit_next = (act_reg == ACT_PROBE) && key_match && (depth_field != 8'd0);

    // Stored depth exceeds the new one exactly when field > depth + 1.
    assign skip = key_match &&
                  ($signed({2'b00, depth_field}) >
                   ($signed({depth_reg[8], depth_reg}) + 10'sd1));
    assign wr_en = cmd.commit && (act_reg == ACT_STORE) && !skip;

    always_comb
    begin
        if ((score_reg[17:15] == 3'b000) || (score_reg[17:15] == 3'b111))
        begin
            score_sat = score_reg[15:0];
        end
        else if (score_reg[17])
        begin
            score_sat = SCORE_NEG;
        end
        else
        begin
            score_sat = SCORE_POS;
        end

        if (depth_reg[8])
        begin
            depth_clamp = 8'd0;
        end
        else if (depth_reg[7:0] > DEPTH_MAX)
        begin
            depth_clamp = DEPTH_MAX;
        end
        else
        begin
            depth_clamp = depth_reg[7:0];
        end
    end

    assign depth_biased = depth_clamp + 8'd1;
    assign new_rec      = {bound_reg, depth_biased, score_sat, move_reg};

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            rd_data_reg <= mem[key[INDEX_BITS-1:0]];
        end
        if (cmd.clr_step)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[idx] <= {key_reg, new_rec};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            act_reg   <= action;
            key_reg   <= key;
            depth_reg <= depth;
            score_reg <= score;
            bound_reg <= bound;
            move_reg  <= move_word;
        end
        if (cmd.commit)
        begin
            hit_reg <= hit_next;
            if (hit_next)
            begin
                move_out_reg  <= rec[MOVE_LSB +: 32];
                score_out_reg <= rec[SCORE_LSB +: 16];
                depth_out_reg <= depth_field - 8'd1;
                bound_out_reg <= (bound_field == BOUND_ALIAS) ? BOUND_EXACT : bound_field;
            end
            else
            begin
                move_out_reg  <= '0;
                score_out_reg <= '0;
                depth_out_reg <= '0;
                bound_out_reg <= '0;
            end
        end
    end

    assign clr_addr_next = cmd.clr_step ? clr_addr_reg + 1'b1 : clr_addr_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            clr_addr_reg  <= clr_addr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign stat.item_clear = (act_reg == ACT_CLEAR);
    assign stat.out_free   = !out_valid_reg || !out_stall;
    assign stat.clr_last   = &clr_addr_reg;

    assign out_valid   = out_valid_reg;
    assign hit         = hit_reg;
    assign found_move  = move_out_reg;
    assign found_score = $signed(score_out_reg);
    assign found_depth = depth_out_reg;
    assign found_bound = bound_out_reg;

endmodule

/* tb/tb_depth_preferred_hash_table.sv */
`timescale 1ns / 1ps

import dpht_pkg::*;

localparam int TB_INDEX_BITS = 12;
localparam int TABLE_ENTRIES = 1 << TB_INDEX_BITS;

// Action code that the block must ignore.
localparam logic [1:0] ACT_UNUSED = 2'd3;

// One input item as the sender presents it.
typedef struct packed {
    logic [1:0]         action;
    logic [63:0]        key;
    logic signed [8:0]  depth;
    logic signed [17:0] score;
    logic [1:0]         bound;
    logic [31:0]        move_word;
} table_op_t;

// One result item.
typedef struct packed {
    logic               hit;
    logic [31:0]        move;
    logic signed [15:0] score;
    logic [7:0]         depth;
    logic [1:0]         bound;
} lookup_result_t;

// Stored record of one slot; depth is kept with a bias of one, so that a
// wiped slot reads back as depth -1.
typedef struct packed {
    logic [1:0]  bound;
    logic [7:0]  depth_b;
    logic [15:0] score;
    logic [31:0] move;
} slot_rec_t;

class hash_table_scoreboard;
    logic [63:0]    key_mem [TABLE_ENTRIES];
    slot_rec_t      rec_mem [TABLE_ENTRIES];
    lookup_result_t expected_q [$];
    int             mismatches;

    function new();
        mismatches = 0;
        wipe();
    endfunction

    function void wipe();
        foreach (key_mem[i])
        begin
            key_mem[i] = '0;
            rec_mem[i] = '0;
        end
    endfunction

    function int outstanding();
        return expected_q.size();
    endfunction

    // Applies an accepted item to the shadow table and queues its result.
    function void note_item(table_op_t op);
        lookup_result_t res;
        slot_rec_t      rec;
        int             idx;
        int             held_depth;
        int             want_depth;
        int             want_score;
        idx        = int'(op.key[TB_INDEX_BITS-1:0]);
        rec        = rec_mem[idx];
        held_depth = int'(rec.depth_b) - 1;
        res        = '0;
        case (op.action)
            ACT_PROBE:
            begin
                if (key_mem[idx] == op.key && held_depth >= 0)
                begin
                    res.hit   = 1'b1;
                    res.move  = rec.move;
                    res.score = rec.score;
                    res.depth = held_depth[7:0];
                    res.bound = (rec.bound == BOUND_ALIAS) ? BOUND_EXACT : rec.bound;
                end
            end
            ACT_STORE:
            begin
                want_depth = int'(op.depth);
                // A deeper entry for the same key is kept.
                if (!(key_mem[idx] == op.key && held_depth > want_depth))
                begin
                    want_score = int'(op.score);
                    if (want_depth < 0)
                        want_depth = 0;
                    if (want_depth > int'(DEPTH_MAX))
                        want_depth = int'(DEPTH_MAX);
                    if (want_score > int'($signed(SCORE_POS)))
                        want_score = int'($signed(SCORE_POS));
                    if (want_score < int'($signed(SCORE_NEG)))
                        want_score = int'($signed(SCORE_NEG));
                    rec.move     = op.move_word;
                    rec.score    = want_score[15:0];
                    rec.depth_b  = want_depth[7:0] + 8'd1;
                    rec.bound    = op.bound;
                    rec_mem[idx] = rec;
                    key_mem[idx] = op.key;
                end
            end
            ACT_CLEAR:
                wipe();
            default:
                ;
        endcase
        expected_q.push_back(res);
    endfunction

    // Compares a result item with the oldest expectation.
    function void check_result(lookup_result_t got);
        lookup_result_t want;
        if (expected_q.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("unexpected result: hit=%0b move=%h score=%0d depth=%0d bound=%0d",
                         got.hit, got.move, got.score, got.depth, got.bound);
            return;
        end
        want = expected_q.pop_front();
        if (got.hit !== want.hit || got.move !== want.move || got.score !== want.score ||
            got.depth !== want.depth || got.bound !== want.bound)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $write("mismatch: expected hit=%0b move=%h score=%0d depth=%0d bound=%0d",
                       want.hit, want.move, want.score, want.depth, want.bound);
                $display(", got hit=%0b move=%h score=%0d depth=%0d bound=%0d",
                         got.hit, got.move, got.score, got.depth, got.bound);
            end
        end
    endfunction
endclass

module tb_depth_preferred_hash_table;

    localparam int CLK_PERIOD  = 20;
    localparam int ITEM_TARGET = 1350;
    // Cycles the receiver refuses results in one go, long enough for the
    // block to fill both its evaluation stage and output register.
    localparam int HOLD_CYCLES = 300;
    // The reset sweep and every clear keep the input stalled for one pass
    // over the table; the limit leaves room for that plus the long hold.
    localparam int IDLE_LIMIT  = 20000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         action;
    logic [63:0]        key;
    logic signed [8:0]  depth;
    logic signed [17:0] score;
    logic [1:0]         bound;
    logic [31:0]        move_word;
    logic               out_valid;
    logic               out_stall;
    logic               hit;
    logic [31:0]        found_move;
    logic signed [15:0] found_score;
    logic [7:0]         found_depth;
    logic [1:0]         found_bound;

    hash_table_scoreboard sb;

    // Requests a long hold-off from the receiver; served only once.
    bit hold_req    = 1'b0;
    bit hold_served = 1'b0;

    // Items left in the current burst of the sender.
    int burst_left = 0;

    // Recently stored keys, so that probes and repeated stores meet live entries.
    logic [63:0] key_pool [64];

    depth_preferred_hash_table #(
        .INDEX_BITS(TB_INDEX_BITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .key         (key),
        .depth       (depth),
        .score       (score),
        .bound       (bound),
        .move_word   (move_word),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .hit         (hit),
        .found_move  (found_move),
        .found_score (found_score),
        .found_depth (found_depth),
        .found_bound (found_bound)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Builds an item from plain values; depth and score are taken as integers
    // so that out-of-range values can be written directly.
    function automatic table_op_t mk(logic [1:0] act, logic [63:0] k, int d, int s,
                                     logic [1:0] b, logic [31:0] mv);
        table_op_t op;
        op.action    = act;
        op.key       = k;
        op.depth     = 9'(d);
        op.score     = 18'(s);
        op.bound     = b;
        op.move_word = mv;
        return op;
    endfunction

    // Random item. Most keys come from the pool of stored keys, some share an
    // index with a pooled key but differ above it, and the rest are fresh,
    // often crowded into a few low indexes to force collisions.
    function automatic table_op_t random_op();
        table_op_t op;
        int        pick;
        int        d;
        int        s;
        logic [63:0] k;
        pick = $urandom_range(0, 999);
        if (pick < 8)
            op.action = ACT_CLEAR;
        else if (pick < 30)
            op.action = ACT_UNUSED;
        else if (pick < 500)
            op.action = ACT_PROBE;
        else
            op.action = ACT_STORE;

        pick = $urandom_range(0, 9);
        k = {$urandom(), $urandom()};
        if (pick <= 5)
            k = key_pool[$urandom_range(0, 63)];
        else if (pick <= 7)
            k[TB_INDEX_BITS-1:0] = key_pool[$urandom_range(0, 63)][TB_INDEX_BITS-1:0];
        else if (pick == 8)
            k[TB_INDEX_BITS-1:0] = TB_INDEX_BITS'($urandom_range(0, 15));
        op.key = k;

        case ($urandom_range(0, 3))
            0: d = int'($urandom_range(0, 511)) - 256;
            3:
            begin
                case ($urandom_range(0, 4))
                    0: d = -256;
                    1: d = -1;
                    2: d = 0;
                    3: d = 254;
                    default: d = 255;
                endcase
            end
            default: d = int'($urandom_range(0, 32)) - 2;
        endcase
        op.depth = 9'(d);

        case ($urandom_range(0, 3))
            0: s = int'($urandom_range(0, 262143)) - 131072;
            1:
            begin
                // Close to the 16-bit limits on either side.
                s = 32760 + int'($urandom_range(0, 16));
                if ($urandom_range(0, 1) == 1)
                    s = -s - 1;
            end
            default: s = int'($urandom_range(0, 65535)) - 32768;
        endcase
        op.score = 18'(s);

        op.bound     = 2'($urandom());
        op.move_word = $urandom();

        if (op.action == ACT_STORE)
            key_pool[$urandom_range(0, 63)] = op.key;
        return op;
    endfunction

    task automatic idle_cycles(int n);
        in_valid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    // Inserts a gap between bursts; a zero gap joins two bursts.
    task automatic pace();
        int gap;
        if (burst_left == 0)
        begin
            case ($urandom_range(0, 9))
                0, 1, 2: gap = 0;
                3, 4, 5, 6, 7: gap = $urandom_range(1, 4);
                default: gap = $urandom_range(5, 25);
            endcase
            if (gap > 0)
                idle_cycles(gap);
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
    endtask

    // Presents one item and holds it until the block takes it.
    task automatic send_item(table_op_t op);
        action    <= op.action;
        key       <= op.key;
        depth     <= op.depth;
        score     <= op.score;
        bound     <= op.bound;
        move_word <= op.move_word;
        in_valid  <= 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        sb.note_item(op);
    endtask

    // Receiver. It stalls in segments of random length, each with a pattern
    // of its own: never, seldom, mostly, or every other cycle. Once asked, it
    // refuses results for a long stretch so that the block backs up.
    initial
    begin
        int mode;
        int seg;
        out_stall <= 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            seg  = $urandom_range(16, 160);
            repeat (seg)
            begin
                @(posedge clk);
                if (hold_req && !hold_served)
                begin
                    hold_served = 1'b1;
                    out_stall <= 1'b1;
                    repeat (HOLD_CYCLES) @(posedge clk);
                end
                case (mode)
                    0: out_stall <= 1'b0;
                    1: out_stall <= ($urandom_range(0, 3) == 0);
                    2: out_stall <= ($urandom_range(0, 4) != 0);
                    default: out_stall <= ~out_stall;
                endcase
            end
        end
    end

    // Every result taken by the receiver goes to the scoreboard. Values are
    // read at the edge before the block updates them, so this matches what
    // the handshake moved.
    always @(posedge clk)
    begin
        lookup_result_t got;
        if (rst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
        begin
            got.hit   = hit;
            got.move  = found_move;
            got.score = found_score;
            got.depth = found_depth;
            got.bound = found_bound;
            sb.check_result(got);
        end
    end

    // Watchdog: ends the run when neither channel has moved an item for too long.
    always @(posedge clk)
    begin
        int quiet;
        if ((in_valid === 1'b1 && in_stall === 1'b0) ||
            (out_valid === 1'b1 && out_stall === 1'b0))
            quiet = 0;
        else
            quiet++;
        if (quiet >= IDLE_LIMIT)
        begin
            $display("timeout: no item moved for %0d cycles", IDLE_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        table_op_t   directed_q [$];
        table_op_t   op;
        logic [63:0] k_a;
        logic [63:0] k_b;
        int          real_items;
        bit          drained_once;

        sb = new();
        foreach (key_pool[i])
            key_pool[i] = {$urandom(), $urandom()};
        key_pool[0] = 64'd0;

        rst_n     <= 1'b0;
        in_valid  <= 1'b0;
        action    <= ACT_PROBE;
        key       <= 64'd0;
        depth     <= 9'sd0;
        score     <= 18'sd0;
        bound     <= BOUND_EXACT;
        move_word <= 32'd0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part. Two keys share an index and differ only in the top bit.
        k_a = 64'h8000_0000_0000_0123;
        k_b = 64'h0000_0000_0000_0123;
        // A wiped slot holds key 0 at depth -1: a probe of key 0 misses, and a
        // store of key 0 below depth -1 is refused.
        directed_q.push_back(mk(ACT_PROBE, 64'd0, 0, 0, BOUND_EXACT, 32'd0));
        directed_q.push_back(mk(ACT_STORE, 64'd0, -5, 77, 2'd1, 32'hDEAD_BEEF));
        directed_q.push_back(mk(ACT_PROBE, 64'd0, 0, 0, BOUND_EXACT, 32'd0));
        // Depth -1 ties with the wiped slot, so it is written and clamps to 0.
        directed_q.push_back(mk(ACT_STORE, 64'd0, -1, 32767, 2'd2, 32'h0000_0001));
        directed_q.push_back(mk(ACT_PROBE, 64'd0, 0, 0, BOUND_EXACT, 32'd0));
        // All-ones fields: depth clamps to the top, score saturates high, and
        // the aliased bound reads back as exact.
        directed_q.push_back(mk(ACT_STORE, '1, 255, 131071, BOUND_ALIAS, 32'hFFFF_FFFF));
        directed_q.push_back(mk(ACT_PROBE, '1, 0, 0, BOUND_EXACT, 32'd0));
        // Lowest depth and score.
        directed_q.push_back(mk(ACT_STORE, k_a, -256, -131072, 2'd2, 32'd0));
        directed_q.push_back(mk(ACT_PROBE, k_a, 0, 0, BOUND_EXACT, 32'd0));
        // Deeper store replaces, shallower one is refused, an equal one replaces.
        directed_q.push_back(mk(ACT_STORE, k_a, 10, 32768, 2'd1, 32'h1234_5678));
        directed_q.push_back(mk(ACT_STORE, k_a, 5, 11, 2'd2, 32'h5555_AAAA));
        directed_q.push_back(mk(ACT_PROBE, k_a, 0, 0, BOUND_EXACT, 32'd0));
        directed_q.push_back(mk(ACT_STORE, k_a, 10, -32769, BOUND_ALIAS, 32'hAAAA_5555));
        directed_q.push_back(mk(ACT_PROBE, k_a, 0, 0, BOUND_EXACT, 32'd0));
        // A different key at the same index always replaces, even shallower.
        directed_q.push_back(mk(ACT_STORE, k_b, 3, -32768, 2'd1, 32'h0F0F_0F0F));
        directed_q.push_back(mk(ACT_PROBE, k_a, 0, 0, BOUND_EXACT, 32'd0));
        directed_q.push_back(mk(ACT_PROBE, k_b, 0, 0, BOUND_EXACT, 32'd0));
        // The unused action changes nothing.
        directed_q.push_back(mk(ACT_UNUSED, k_b, 200, 5, 2'd2, 32'h1111_1111));
        directed_q.push_back(mk(ACT_PROBE, k_b, 0, 0, BOUND_EXACT, 32'd0));
        // A clear wipes everything.
        directed_q.push_back(mk(ACT_CLEAR, 64'd0, 0, 0, BOUND_EXACT, 32'd0));
        directed_q.push_back(mk(ACT_PROBE, k_b, 0, 0, BOUND_EXACT, 32'd0));
        directed_q.push_back(mk(ACT_PROBE, '1, 0, 0, BOUND_EXACT, 32'd0));
        directed_q.push_back(mk(ACT_STORE, 64'd0, -2, 9, 2'd1, 32'h2222_2222));
        directed_q.push_back(mk(ACT_PROBE, 64'd0, 0, 0, BOUND_EXACT, 32'd0));

        real_items = 0;
        foreach (directed_q[i])
        begin
            pace();
            send_item(directed_q[i]);
            if (directed_q[i].action != ACT_UNUSED)
                real_items++;
        end

        // Random part. Items of the unused action are not counted.
        drained_once = 1'b0;
        while (real_items < ITEM_TARGET)
        begin
            // Ask for the long hold-off and keep offering items through it.
            if (real_items >= 450 && !hold_req)
            begin
                hold_req   <= 1'b1;
                burst_left = 80;
            end
            // Once, let the block drain completely before going on.
            if (real_items >= 900 && !drained_once)
            begin
                drained_once = 1'b1;
                idle_cycles(1);
                while (sb.outstanding() != 0)
                    @(posedge clk);
                burst_left = 0;
            end
            op = random_op();
            pace();
            send_item(op);
            if (op.action != ACT_UNUSED)
                real_items++;
        end
        in_valid <= 1'b0;

        // Wait for the last results, then a few cycles for anything stray.
        while (sb.outstanding() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (sb.mismatches == 0 && sb.outstanding() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
